// ===== hw/rtl/ale_pkg.sv =====
package ale_pkg;

   localparam int DEPTH_DEFAULT      = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int CMD_W   = 4;
   localparam int INDEX_W = 6;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int TOTAL_W = 7;

   localparam logic [CMD_W-1:0] CMD_INS_START = 4'd0;
   localparam logic [CMD_W-1:0] CMD_INS_END   = 4'd1;
   localparam logic [CMD_W-1:0] CMD_INS_AT    = 4'd2;
   localparam logic [CMD_W-1:0] CMD_RM_START  = 4'd3;
   localparam logic [CMD_W-1:0] CMD_RM_END    = 4'd4;
   localparam logic [CMD_W-1:0] CMD_RM_AT     = 4'd5;
   localparam logic [CMD_W-1:0] CMD_REPLACE   = 4'd6;
   localparam logic [CMD_W-1:0] CMD_SEARCH    = 4'd7;
   localparam logic [CMD_W-1:0] CMD_SORT      = 4'd8;
   localparam logic [CMD_W-1:0] CMD_DUPCHECK  = 4'd9;
   localparam logic [CMD_W-1:0] CMD_READ      = 4'd10;
   localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd11;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic eq;
      logic lt;
   } cmp_result_type;

endpackage

// ===== hw/rtl/ale_ram.sv =====
module ale_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== hw/rtl/ale_cmp.sv =====
module ale_cmp #(
   parameter int WIDTH = 32
) (
   input  logic [WIDTH-1:0]       a,
   input  logic [WIDTH-1:0]       b,
   output ale_pkg::cmp_result_type result
);

   import ale_pkg::*;

   always_comb begin
      result.eq = (a == b);
      result.lt = ($signed(a) < $signed(b));
   end

endmodule

// ===== hw/rtl/array_list_engine.sv =====
// channel   | ports                               | handshake
// ----------+-------------------------------------+------------------------------
// request   | req_cmd, req_index, req_value       | taken when start && !busy
// result    | rsp_status .. rsp_has_duplicate     | rsp_valid, one cycle, no stall
//
// one request at a time; the result strobe comes in the cycle after the last step
// list walks use the single ram port pair: each element moved or scanned is first read, then written or checked
// insert/remove shift the tail, search and dupcheck scan, sort repeats bubble
// passes until one makes no swap; the shared compare unit does one test per step
// reset empties the list (count 0); ram contents are left as they are
// the receiver cannot stall: a result is shown for exactly one cycle
module array_list_engine #(
   parameter int DEPTH      = ale_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = ale_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [ale_pkg::CMD_W-1:0]         req_cmd,
   input  logic [ale_pkg::INDEX_W-1:0]       req_index,
   input  logic signed [ale_pkg::VALUE_W-1:0] req_value,
   output logic                              rsp_valid,
   output logic [ale_pkg::STAT_W-1:0]        rsp_status,
   output logic                              rsp_found,
   output logic [ale_pkg::INDEX_W-1:0]       rsp_position,
   output logic signed [ale_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [ale_pkg::TOTAL_W-1:0]       rsp_entry_total,
   output logic                              rsp_already_sorted,
   output logic                              rsp_has_duplicate
);

   import ale_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_INS      = 5'd1;
   localparam logic [4:0] S_INS_MV   = 5'd2;
   localparam logic [4:0] S_RM       = 5'd3;
   localparam logic [4:0] S_RM_MV    = 5'd4;
   localparam logic [4:0] S_RD_WAIT  = 5'd5;
   localparam logic [4:0] S_SRCH     = 5'd6;
   localparam logic [4:0] S_SRCH_CK  = 5'd7;
   localparam logic [4:0] S_SORT_LD  = 5'd8;
   localparam logic [4:0] S_SORT_CUR = 5'd9;
   localparam logic [4:0] S_SORT     = 5'd10;
   localparam logic [4:0] S_SORT_CK  = 5'd11;
   localparam logic [4:0] S_DUP      = 5'd12;
   localparam logic [4:0] S_DUP_HOLD = 5'd13;
   localparam logic [4:0] S_DUP_RD   = 5'd14;
   localparam logic [4:0] S_DUP_CK   = 5'd15;

   logic [4:0]            state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         ptr_ff, ptr_in;
   logic [CW-1:0]         tgt_ff, tgt_in;
   logic [DATA_WIDTH-1:0] cur_ff, cur_in;
   logic                  first_ff, first_in;
   logic                  swap_ff, swap_in;
   logic                  valid_ff, valid_in;
   logic [STAT_W-1:0]     status_ff, status_in;
   logic                  found_ff, found_in;
   logic [INDEX_W-1:0]    pos_ff, pos_in;
   logic [VALUE_W-1:0]    rdv_ff, rdv_in;
   logic                  srt_ff, srt_in;
   logic                  dup_ff, dup_in;

   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;
   logic [DATA_WIDTH-1:0] val_ext;
   logic [CW-1:0]         ptr_p1, ptr_m1, tgt_p1;
   logic [IW-1:0]         ix, nx;
   cmp_result_type        cmp;

   ale_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ale_cmp #(.WIDTH(DATA_WIDTH)) u_cmp (
      .a      (rd_data),
      .b      (cur_ff),
      .result (cmp)
   );

   assign val_ext = DATA_WIDTH'(req_value);
   assign ptr_p1  = ptr_ff + CW'(1);
   assign ptr_m1  = ptr_ff - CW'(1);
   assign tgt_p1  = tgt_ff + CW'(1);
   assign ix      = IW'(req_index);
   assign nx      = IW'(cnt_ff);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ptr_in    = ptr_ff;
      tgt_in    = tgt_ff;
      cur_in    = cur_ff;
      first_in  = first_ff;
      swap_in   = swap_ff;
      valid_in  = 1'b0;
      status_in = status_ff;
      found_in  = found_ff;
      pos_in    = pos_ff;
      rdv_in    = rdv_ff;
      srt_in    = srt_ff;
      dup_in    = dup_ff;
      wr_en     = 1'b0;
      wr_addr   = AW'(ptr_ff);
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = AW'(ptr_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               status_in = ST_OK;
               found_in  = 1'b0;
               pos_in    = '0;
               rdv_in    = '0;
               srt_in    = 1'b0;
               dup_in    = 1'b0;
               cur_in    = val_ext;
               ptr_in    = '0;
               tgt_in    = '0;
               unique case (req_cmd)
                  CMD_INS_START, CMD_INS_END, CMD_INS_AT: begin
                     if (req_cmd == CMD_INS_AT && ix > nx) begin
                        status_in = ST_RANGE;
                        valid_in  = 1'b1;
                     end else if (cnt_ff == CW'(DEPTH)) begin
                        status_in = ST_FULL;
                        valid_in  = 1'b1;
                     end else begin
                        ptr_in = cnt_ff;
                        if (req_cmd == CMD_INS_START) begin
                           tgt_in = '0;
                        end else if (req_cmd == CMD_INS_END) begin
                           tgt_in = cnt_ff;
                        end else begin
                           tgt_in = CW'(req_index);
                        end
                        state_in = S_INS;
                     end
                  end
                  CMD_RM_START, CMD_RM_END, CMD_RM_AT, CMD_REPLACE, CMD_READ: begin
                     if (cnt_ff == '0) begin
                        status_in = ST_EMPTY;
                        valid_in  = 1'b1;
                     end else if (req_cmd == CMD_RM_START) begin
                        state_in = S_RM;
                     end else if (req_cmd == CMD_RM_END) begin
                        cnt_in   = cnt_ff - CW'(1);
                        valid_in = 1'b1;
                     end else if (ix >= nx) begin
                        status_in = ST_RANGE;
                        valid_in  = 1'b1;
                     end else if (req_cmd == CMD_RM_AT) begin
                        ptr_in   = CW'(req_index);
                        state_in = S_RM;
                     end else if (req_cmd == CMD_REPLACE) begin
                        wr_en    = 1'b1;
                        wr_addr  = AW'(req_index);
                        wr_data  = val_ext;
                        valid_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(req_index);
                        state_in = S_RD_WAIT;
                     end
                  end
                  CMD_SEARCH: begin
                     state_in = S_SRCH;
                  end
                  CMD_SORT: begin
                     if (cnt_ff <= CW'(1)) begin
                        srt_in   = 1'b1;
                        valid_in = 1'b1;
                     end else begin
                        first_in = 1'b1;
                        state_in = S_SORT_LD;
                     end
                  end
                  CMD_DUPCHECK: begin
                     state_in = S_DUP;
                  end
                  CMD_CLEAR: begin
                     cnt_in   = '0;
                     valid_in = 1'b1;
                  end
                  default: begin
                     valid_in = 1'b1;
                  end
               endcase
            end
         end
         // shift up from the tail, then drop the new word into the gap
         S_INS: begin
            if (ptr_ff == tgt_ff) begin
               wr_en    = 1'b1;
               wr_addr  = AW'(ptr_ff);
               wr_data  = cur_ff;
               cnt_in   = cnt_ff + CW'(1);
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(ptr_m1);
               state_in = S_INS_MV;
            end
         end
         S_INS_MV: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(ptr_ff);
            ptr_in   = ptr_m1;
            state_in = S_INS;
         end
         S_RM: begin
            if (ptr_p1 < cnt_ff) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(ptr_p1);
               state_in = S_RM_MV;
            end else begin
               cnt_in   = cnt_ff - CW'(1);
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_RM_MV: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(ptr_ff);
            ptr_in   = ptr_p1;
            state_in = S_RM;
         end
         S_RD_WAIT: begin
            rdv_in   = VALUE_W'(rd_data);
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_SRCH: begin
            if (ptr_ff < cnt_ff) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(ptr_ff);
               state_in = S_SRCH_CK;
            end else begin
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SRCH_CK: begin
            if (cmp.eq) begin
               found_in = 1'b1;
               pos_in   = INDEX_W'(ptr_ff);
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               ptr_in   = ptr_p1;
               state_in = S_SRCH;
            end
         end
         // one bubble pass: cur_ff carries the running maximum
         S_SORT_LD: begin
            rd_en    = 1'b1;
            rd_addr  = '0;
            ptr_in   = CW'(1);
            swap_in  = 1'b0;
            state_in = S_SORT_CUR;
         end
         S_SORT_CUR: begin
            cur_in   = rd_data;
            state_in = S_SORT;
         end
         S_SORT: begin
            if (ptr_ff < cnt_ff) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(ptr_ff);
               state_in = S_SORT_CK;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = AW'(ptr_m1);
               wr_data  = cur_ff;
               first_in = 1'b0;
               if (first_ff) begin
                  srt_in = !swap_ff;
               end
               if (swap_ff) begin
                  state_in = S_SORT_LD;
               end else begin
                  valid_in = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_SORT_CK: begin
            wr_en   = 1'b1;
            wr_addr = AW'(ptr_m1);
            if (cmp.lt) begin
               wr_data = rd_data;
               swap_in = 1'b1;
            end else begin
               wr_data = cur_ff;
               cur_in  = rd_data;
            end
            ptr_in   = ptr_p1;
            state_in = S_SORT;
         end
         S_DUP: begin
            if (tgt_p1 < cnt_ff) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(tgt_ff);
               state_in = S_DUP_HOLD;
            end else begin
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DUP_HOLD: begin
            cur_in   = rd_data;
            ptr_in   = tgt_p1;
            state_in = S_DUP_RD;
         end
         S_DUP_RD: begin
            if (ptr_ff < cnt_ff) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(ptr_ff);
               state_in = S_DUP_CK;
            end else begin
               tgt_in   = tgt_p1;
               state_in = S_DUP;
            end
         end
         S_DUP_CK: begin
            if (cmp.eq) begin
               dup_in   = 1'b1;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               ptr_in   = ptr_p1;
               state_in = S_DUP_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
         first_ff <= 1'b0;
         swap_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
         first_ff <= first_in;
         swap_ff  <= swap_in;
      end
      ptr_ff    <= ptr_in;
      tgt_ff    <= tgt_in;
      cur_ff    <= cur_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      pos_ff    <= pos_in;
      rdv_ff    <= rdv_in;
      srt_ff    <= srt_in;
      dup_ff    <= dup_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_found          = found_ff;
   assign rsp_position       = pos_ff;
   assign rsp_read_value     = rdv_ff;
   assign rsp_entry_total    = TOTAL_W'(cnt_ff);
   assign rsp_already_sorted = srt_ff;
   assign rsp_has_duplicate  = dup_ff;

endmodule

// ===== hw/rtl/ale_checker.sv =====
module ale_checker #(
   parameter int DEPTH = ale_pkg::DEPTH_DEFAULT
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic [ale_pkg::STAT_W-1:0] rsp_status,
   input logic                       rsp_found,
   input logic [ale_pkg::TOTAL_W-1:0] rsp_entry_total
);

   import ale_pkg::*;

   // a result never shows while a request is still being worked on
   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // every accepted request either starts work or answers right away
   a_accept_moves: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request vanished");

   // long commands end with a result
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_entry_total <= TOTAL_W'(DEPTH)))
      else $error("entry total beyond depth");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == ST_OK))
      else $error("match reported with error status");

endmodule

bind array_list_engine ale_checker #(.DEPTH(DEPTH)) u_ale_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_found       (rsp_found),
   .rsp_entry_total (rsp_entry_total)
);

// ===== sim/array_list_engine_tb.sv =====
`timescale 1ns / 1ps

module array_list_engine_tb;
   import ale_pkg::*;

   localparam int LIST_DEPTH = 64;
   localparam int RANDOM_REQS = 1030;
   localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 4'd12;
   localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 4'd15;

   typedef enum int {GROW, SHRINK, MIXED} mix_mode_type;

   typedef struct {
      logic [CMD_W-1:0]          cmd;
      logic [INDEX_W-1:0]        idx;
      logic signed [VALUE_W-1:0] val;
      bit                        drain;
   } list_req_type;

   typedef struct packed {
      logic [STAT_W-1:0]         status;
      logic                      found;
      logic [INDEX_W-1:0]        position;
      logic signed [VALUE_W-1:0] read_value;
      logic [TOTAL_W-1:0]        entry_total;
      logic                      already_sorted;
      logic                      has_duplicate;
   } list_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [CMD_W-1:0] req_cmd = '0;
   logic [INDEX_W-1:0] req_index = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic rsp_valid;
   logic [STAT_W-1:0] rsp_status;
   logic rsp_found;
   logic [INDEX_W-1:0] rsp_position;
   logic signed [VALUE_W-1:0] rsp_read_value;
   logic [TOTAL_W-1:0] rsp_entry_total;
   logic rsp_already_sorted;
   logic rsp_has_duplicate;

   list_req_type pending_reqs[$];
   list_rsp_type expected_rsps[$];

   // predictor copy of the list
   logic signed [VALUE_W-1:0] list_mem [LIST_DEPTH];
   int list_len = 0;

   int gen_len = 0;
   int n_sent = 0;
   int n_checked = 0;
   int n_errors = 0;
   int n_full = 0;
   int n_empty = 0;
   int n_found = 0;
   int peak_len = 0;
   int hold_cnt = 0;
   bit idle_mode = 1'b0;
   bit stim_ready = 1'b0;

   array_list_engine dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_index(req_index), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_found(rsp_found),
      .rsp_position(rsp_position), .rsp_read_value(rsp_read_value),
      .rsp_entry_total(rsp_entry_total), .rsp_already_sorted(rsp_already_sorted),
      .rsp_has_duplicate(rsp_has_duplicate)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic list_rsp_type list_outcome(logic [CMD_W-1:0] cmd,
                                                 logic [INDEX_W-1:0] idx,
                                                 logic signed [VALUE_W-1:0] val);
      list_rsp_type r;
      int i;
      int j;
      int pos;
      logic signed [VALUE_W-1:0] t;
      r = '0;
      pos = idx;
      case (cmd)
         CMD_INS_START, CMD_INS_END, CMD_INS_AT: begin
            if (cmd == CMD_INS_AT && pos > list_len)
               r.status = ST_RANGE;
            else if (list_len >= LIST_DEPTH)
               r.status = ST_FULL;
            else begin
               if (cmd == CMD_INS_START) pos = 0;
               if (cmd == CMD_INS_END) pos = list_len;
               for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
               list_mem[pos] = val;
               list_len++;
            end
         end
         CMD_RM_START, CMD_RM_END, CMD_RM_AT, CMD_REPLACE, CMD_READ: begin
            if (list_len == 0)
               r.status = ST_EMPTY;
            else if (cmd == CMD_RM_END)
               list_len--;
            else if (cmd != CMD_RM_START && pos >= list_len)
               r.status = ST_RANGE;
            else if (cmd == CMD_REPLACE)
               list_mem[pos] = val;
            else if (cmd == CMD_READ)
               r.read_value = list_mem[pos];
            else begin
               if (cmd == CMD_RM_START) pos = 0;
               for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
               list_len--;
            end
         end
         CMD_SEARCH: begin
            for (i = 0; i < list_len && !r.found; i++)
               if (list_mem[i] == val) begin
                  r.found = 1'b1;
                  r.position = INDEX_W'(i);
               end
         end
         CMD_SORT: begin
            r.already_sorted = 1'b1;
            for (i = 0; i + 1 < list_len; i++)
               if (list_mem[i+1] < list_mem[i]) r.already_sorted = 1'b0;
            for (i = 1; i < list_len; i++) begin
               t = list_mem[i];
               for (j = i; j > 0 && list_mem[j-1] > t; j--) list_mem[j] = list_mem[j-1];
               list_mem[j] = t;
            end
         end
         CMD_DUPCHECK: begin
            for (i = 0; i < list_len; i++)
               for (j = i + 1; j < list_len; j++)
                  if (list_mem[i] == list_mem[j]) r.has_duplicate = 1'b1;
         end
         CMD_CLEAR: list_len = 0;
         default: ;
      endcase
      r.entry_total = TOTAL_W'(list_len);
      return r;
   endfunction

   // queues a request and tracks the list length it will leave behind
   task automatic add_req(logic [CMD_W-1:0] cmd, int idx, logic signed [VALUE_W-1:0] val,
                          bit drain = 1'b0);
      list_req_type q;
      q.cmd = cmd;
      q.idx = INDEX_W'(idx);
      q.val = val;
      q.drain = drain;
      pending_reqs.push_back(q);
      case (cmd)
         CMD_INS_START, CMD_INS_END: if (gen_len < LIST_DEPTH) gen_len++;
         CMD_INS_AT: if (idx <= gen_len && gen_len < LIST_DEPTH) gen_len++;
         CMD_RM_START, CMD_RM_END: if (gen_len > 0) gen_len--;
         CMD_RM_AT: if (idx < gen_len) gen_len--;
         CMD_CLEAR: gen_len = 0;
         default: ;
      endcase
   endtask

   function automatic logic signed [VALUE_W-1:0] draw_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return $signed($urandom_range(0, 15)) - 8;
      if (r < 50) return 32'sh7fffffff;
      if (r < 55) return 32'sh80000000;
      return $urandom;
   endfunction

   function automatic int draw_index();
      if ($urandom_range(0, 4) == 0) return $urandom_range(0, 63);
      return (gen_len > 63) ? $urandom_range(0, 63) : $urandom_range(0, gen_len);
   endfunction

   function automatic logic [CMD_W-1:0] draw_cmd(mix_mode_type mode);
      int r;
      r = $urandom_range(0, 99);
      if (r < 2) return CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
      if (r < 4) return CMD_SORT;
      if (r < 7) return CMD_DUPCHECK;
      if (r < 8) return CMD_CLEAR;
      if (r < 18) return CMD_SEARCH;
      if (r < 28) return CMD_READ;
      if (r < 34) return CMD_REPLACE;
      r = $urandom_range(0, 99);
      if ((mode == GROW && r < 85) || (mode == SHRINK && r < 15) ||
          (mode == MIXED && r < 50))
         return CMD_W'($urandom_range(CMD_INS_START, CMD_INS_AT));
      return CMD_W'($urandom_range(CMD_RM_START, CMD_RM_AT));
   endfunction

   initial begin
      mix_mode_type mode;
      int k;
      // empty-list cases, then edge cases on a short list
      add_req(CMD_RM_START, 0, 0);
      add_req(CMD_RM_END, 0, 0);
      add_req(CMD_RM_AT, 0, 0);
      add_req(CMD_REPLACE, 0, 5);
      add_req(CMD_READ, 0, 0);
      add_req(CMD_SEARCH, 0, 0);
      add_req(CMD_SORT, 0, 0);
      add_req(CMD_DUPCHECK, 0, 0);
      add_req(CMD_INS_AT, 1, 3);
      add_req(CMD_INS_AT, 0, 32'sh7fffffff);
      add_req(CMD_SORT, 0, 0);
      add_req(CMD_DUPCHECK, 0, 0);
      add_req(CMD_INS_END, 63, 32'sh80000000);
      add_req(CMD_INS_START, 0, -1);
      add_req(CMD_INS_AT, 3, 0);
      add_req(CMD_SEARCH, 0, 32'sh80000000);
      add_req(CMD_SEARCH, 0, 42);
      add_req(CMD_RM_AT, 63, 0);
      add_req(CMD_READ, 4, 0);
      add_req(CMD_REPLACE, 1, -1, 1'b1);
      add_req(CMD_DUPCHECK, 0, 0);
      add_req(CMD_SORT, 0, 0);
      add_req(CMD_SORT, 0, 0);
      add_req(CMD_READ, 3, 0);
      add_req(CMD_UNUSED_LAST, 63, -1);
      add_req(CMD_CLEAR, 0, 0);
      mode = GROW;
      for (k = 0; k < RANDOM_REQS; k++) begin
         if (k % 70 == 0) mode = mix_mode_type'($urandom_range(0, 2));
         add_req(draw_cmd(mode), draw_index(), draw_value(), k % 150 == 75);
      end
      stim_ready = 1'b1;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: a request stays up until taken, then in idle mode a random gap before the next
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) begin
            expected_rsps.push_back(list_outcome(req_cmd, req_index, req_value));
            n_sent++;
            if ($urandom_range(0, 39) == 0) idle_mode = !idle_mode;
            hold_cnt = idle_mode ? $urandom_range(0, 13) : 0;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            start <= 1'b0;
         end else if (stim_ready && pending_reqs.size() > 0 &&
                      !(pending_reqs[0].drain && expected_rsps.size() > 0)) begin
            req_cmd <= pending_reqs[0].cmd;
            req_index <= pending_reqs[0].idx;
            req_value <= pending_reqs[0].val;
            start <= 1'b1;
            void'(pending_reqs.pop_front());
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         n_errors++;
      end
   endfunction

   // monitor
   always @(posedge clock) begin
      list_rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response, expected none actual status %0d",
                     $time, rsp_status);
            n_errors++;
         end else begin
            e = expected_rsps.pop_front();
            check_field("status", e.status, rsp_status);
            check_field("found", e.found, rsp_found);
            check_field("position", e.position, rsp_position);
            check_field("read_value", e.read_value, rsp_read_value);
            check_field("entry_total", e.entry_total, rsp_entry_total);
            check_field("already_sorted", e.already_sorted, rsp_already_sorted);
            check_field("has_duplicate", e.has_duplicate, rsp_has_duplicate);
            n_checked++;
            if (e.status == ST_FULL) n_full++;
            if (e.status == ST_EMPTY) n_empty++;
            if (e.found) n_found++;
            if (e.entry_total > peak_len) peak_len = e.entry_total;
         end
      end
   end

   initial begin
      wait (stim_ready);
      while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      $display("requests sent %0d, responses checked %0d, peak list length %0d",
               n_sent, n_checked, peak_len);
      $display("full-list rejects %0d, empty-list rejects %0d, search hits %0d",
               n_full, n_empty, n_found);
      if (n_errors == 0 && expected_rsps.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("timeout with %0d responses outstanding", expected_rsps.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/ale_pkg.sv
hw/rtl/ale_ram.sv
hw/rtl/ale_cmp.sv
hw/rtl/array_list_engine.sv
hw/rtl/ale_checker.sv
sim/array_list_engine_tb.sv
